### hw/rtl/grc_pkg.sv
`default_nettype none
package grc_pkg;
	localparam int unsigned COL_W = 10;
	localparam int unsigned DIR_W = 16;
	localparam int unsigned CFG_W = 11;
	localparam int unsigned DIST_W = 24;
	localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
	localparam logic [15:0] LINE_MAX = 16'hFFFF;
	localparam logic [11:0] PLANE_Y_Q12 = 12'd2703;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic signed [DIR_W-1:0] rx;
		logic signed [DIR_W-1:0] ry;
	} ray_t;
endpackage
`default_nettype wire

### hw/rtl/grid_raycast_column_span_top.sv
`default_nettype none
// Channel   Direction  Fields
// s_axis    in         tdata: column, dir_x, dir_y
// m_axis    out        tdata: column_out, ceiling_end, wall_end, hit_side
// cfg       in         wr_en, wr_index, wr_data
// A request passes from acceptance through the front's ray division and then the back end,
// which runs two step divisions, a grid walk of 1 to 4*MAP_SIZE steps and a line-height
// division in series; each of those three divisions is skipped when its divisor is zero.
// The back end holds one request at a time, which sets the rate; the front prepares
// the next ray meanwhile and then stalls s_axis until the back takes it.
// Reset clears control state and loads default screen size; m_axis waits stall the back.
module grid_raycast_column_span_top #(
	parameter int unsigned MAP_SIZE = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [10:0] wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata, // column[9:0], dir_x[25:10], dir_y[41:26]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// column_out[9:0], ceiling_end[19:10], wall_end[29:20], hit_side[30]
	output logic [31:0]      m_axis_tdata
);
	logic [10:0] width_q, height_q;
	logic qv, qr;
	grc_pkg::ray_t qd;
	logic [9:0] co, ce, we;
	logic hs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd320;
			height_q <= 11'd180;
		end else if (wr_en) begin
			if (wr_index == grc_pkg::REG_WIDTH) width_q <= wr_data;
			else height_q <= wr_data;
		end
	end

	grc_front u_front (
		.clk(clk), .arst_n(arst_n), .screen_width(width_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.column(s_axis_tdata[9:0]), .dir_x(s_axis_tdata[25:10]), .dir_y(s_axis_tdata[41:26]),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	grc_back #(.MAP_SIZE(MAP_SIZE)) u_back (
		.clk(clk), .arst_n(arst_n), .screen_width(width_q),
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.column_out(co), .ceiling_end(ce), .wall_end(we), .hit_side(hs)
	);

	assign m_axis_tdata = {1'b0, hs, we, ce, co};
endmodule
`default_nettype wire

### hw/rtl/grc_divider.sv
`default_nettype none
module grc_divider #(
	parameter int unsigned NUM_W = 29,
	parameter int unsigned DEN_W = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic [NUM_W-1:0]      quot
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] shifted;

	assign shifted = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quot <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!trial[DEN_W]) begin
				rem_q <= trial;
				quot <= {quot[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quot <= {quot[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/grc_front.sv
`default_nettype none
module grc_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [grc_pkg::CFG_W-1:0]   screen_width,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [grc_pkg::COL_W-1:0]   column,
	input  wire logic signed [15:0]          dir_x,
	input  wire logic signed [15:0]          dir_y,
	output logic                             q_valid,
	input  wire logic                        q_ready,
	output grc_pkg::ray_t                    q_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0] state_q;
	logic [grc_pkg::COL_W-1:0] col_q;
	logic signed [15:0] dx_q, dy_q;
	logic div_start, div_busy, div_done;
	logic [22:0] div_quot;
	logic [22:0] num;
	logic [10:0] w;
	logic signed [23:0] cam;
	logic signed [37:0] prod;
	logic signed [23:0] yoff;
	logic signed [24:0] sx, sy;

	function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
		if (v > 25'sd32767) return 16'sh7FFF;
		if (v < -25'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	assign w = (screen_width == '0) ? 11'd1 : screen_width;
	assign num = {col_q, 13'd0};
	assign div_start = (state_q == ST_IDLE) && in_valid;
	assign in_ready = (state_q == ST_IDLE);

	grc_divider #(.NUM_W(23), .DEN_W(11)) u_div (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV && !div_busy && !div_done),
		.num(num), .den(w), .busy(div_busy), .done(div_done), .quot(div_quot)
	);

	assign cam = $signed({1'b0, div_quot}) - 24'sd4096;
	assign prod = 38'(cam) * $signed({1'b0, grc_pkg::PLANE_Y_Q12});
	assign yoff = 24'(prod >>> 12);
	assign sx = 25'(dx_q) + 25'(cam);
	assign sy = 25'(dy_q) + 25'(yoff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			q_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
						q_valid <= 1'b1;
					end
				end
				ST_OUT: begin
					if (q_ready) begin
						q_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			col_q <= column;
			dx_q <= dir_x;
			dy_q <= dir_y;
		end
		if (state_q == ST_DIV && div_done) begin
			q_data.column <= col_q;
			q_data.rx <= sat16(sx);
			q_data.ry <= sat16(sy);
		end
	end
endmodule
`default_nettype wire

### hw/rtl/grc_back.sv
`default_nettype none
module grc_back #(
	parameter int unsigned MAP_SIZE = 10
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [grc_pkg::CFG_W-1:0] screen_width,
	input  wire logic                      q_valid,
	output logic                           q_ready,
	input  wire grc_pkg::ray_t             q_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [grc_pkg::COL_W-1:0]      column_out,
	output logic [9:0]                     ceiling_end,
	output logic [9:0]                     wall_end,
	output logic                           hit_side
);
	localparam int unsigned CW = $clog2(MAP_SIZE) + 2;
	localparam int unsigned IW = $clog2(MAP_SIZE * MAP_SIZE);
	localparam int unsigned SW = $clog2(4 * MAP_SIZE + 1);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DX = 4'd1;
	localparam logic [3:0] ST_DXW = 4'd2;
	localparam logic [3:0] ST_DY = 4'd3;
	localparam logic [3:0] ST_DYW = 4'd4;
	localparam logic [3:0] ST_WALK = 4'd5;
	localparam logic [3:0] ST_LH = 4'd6;
	localparam logic [3:0] ST_LHW = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q;
	grc_pkg::ray_t ray_q;
	logic [23:0] ddx_q, ddy_q, sdx_q, sdy_q, perp_q;
	logic signed [CW-1:0] mx_q, my_q;
	logic [SW-1:0] steps_q;
	logic side_q;
	logic [15:0] lh_q;

	logic dstart;
	logic [39:0] dnum;
	logic [23:0] dden;
	logic dbusy, ddone;
	logic [39:0] dquot;
	logic [15:0] arx, ary;

	assign arx = ray_q.rx[15] ? 16'(-ray_q.rx) : ray_q.rx;
	assign ary = ray_q.ry[15] ? 16'(-ray_q.ry) : ray_q.ry;

	always_comb begin
		dnum = 40'd1 << 28;
		dden = {8'd0, arx};
		dstart = 1'b0;
		case (state_q)
			ST_DX: begin
				dstart = (ray_q.rx != '0);
			end
			ST_DY: begin
				dden = {8'd0, ary};
				dstart = (ray_q.ry != '0);
			end
			ST_LH: begin
				dnum = {13'd0, screen_width[10:1], 17'd0} >> 1;
				dden = perp_q;
				dstart = (perp_q != '0);
			end
			default: ;
		endcase
	end

	grc_divider #(.NUM_W(40), .DEN_W(24)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .done(ddone), .quot(dquot)
	);

	function automatic logic [23:0] sat24(input logic [39:0] v);
		return (v > 40'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX : v[23:0];
	endfunction
	function automatic logic [23:0] sadd(input logic [23:0] a, input logic [23:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[24] ? grc_pkg::DIST_MAX : s[23:0];
	endfunction

	logic stepx;
	logic signed [CW-1:0] nmx, nmy;
	logic wall;
	logic [IW-1:0] cell_idx;
	logic [23:0] nsdx, nsdy;
	logic [MAP_SIZE*MAP_SIZE-1:0] wall_map;
	always_comb begin
		for (int i = 0; i < MAP_SIZE; i++)
			for (int j = 0; j < MAP_SIZE; j++)
				wall_map[i*MAP_SIZE+j] = (i == 0 || j == 0 || i == MAP_SIZE-1 || j == MAP_SIZE-1);
	end
	assign stepx = sdx_q < sdy_q;
	assign nsdx = sadd(sdx_q, ddx_q);
	assign nsdy = sadd(sdy_q, ddy_q);
	assign nmx = stepx ? (ray_q.rx[15] ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign nmy = stepx ? my_q : (ray_q.ry[15] ? my_q - 1'b1 : my_q + 1'b1);
	assign cell_idx = IW'(nmx) * IW'(MAP_SIZE) + IW'(nmy);
	always_comb begin
		if (nmx < 0 || nmy < 0 || nmx >= CW'(MAP_SIZE) || nmy >= CW'(MAP_SIZE))
			wall = 1'b1;
		else
			wall = wall_map[cell_idx];
	end

	logic [9:0] h, hh, lh2;
	logic [15:0] e;
	assign h = screen_width[10:1];
	assign hh = {1'b0, h[9:1]};
	assign lh2 = lh_q[10:1];
	assign e = {1'b0, lh_q[15:1]} + 16'(hh);

	assign q_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_DX;
				ST_DX: state_q <= (ray_q.rx != '0) ? ST_DXW : ST_DY;
				ST_DXW: if (ddone) state_q <= ST_DY;
				ST_DY: state_q <= (ray_q.ry != '0) ? ST_DYW : ST_WALK;
				ST_DYW: if (ddone) state_q <= ST_WALK;
				ST_WALK: if (wall || steps_q == SW'(4*MAP_SIZE-1)) state_q <= ST_LH;
				ST_LH: state_q <= (perp_q != '0) ? ST_LHW : ST_FIN;
				ST_LHW: if (ddone) state_q <= ST_FIN;
				ST_FIN: begin
					state_q <= ST_OUT;
					out_valid <= 1'b1;
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ray_q <= q_data;
				ddx_q <= grc_pkg::DIST_MAX;
				ddy_q <= grc_pkg::DIST_MAX;
				mx_q <= CW'(5);
				my_q <= CW'(5);
				steps_q <= '0;
			end
			ST_DXW: if (ddone) ddx_q <= sat24(dquot);
			ST_DYW: if (ddone) ddy_q <= sat24(dquot);
			ST_WALK: begin
				steps_q <= steps_q + 1'b1;
				mx_q <= nmx;
				my_q <= nmy;
				side_q <= !stepx;
				if (stepx) begin
					sdx_q <= nsdx;
					perp_q <= nsdx - ddx_q;
				end else begin
					sdy_q <= nsdy;
					perp_q <= nsdy - ddy_q;
				end
			end
			ST_LH: lh_q <= grc_pkg::LINE_MAX;
			ST_LHW: if (ddone)
				lh_q <= (dquot > 40'(grc_pkg::LINE_MAX)) ? grc_pkg::LINE_MAX : dquot[15:0];
			ST_FIN: begin
				column_out <= ray_q.column;
				hit_side <= side_q;
				ceiling_end <= (lh_q[15:1] > 15'(hh)) ? 10'd0 : hh - lh2;
				if (e >= 16'(h)) wall_end <= (h != '0) ? h - 1'b1 : 10'd0;
				else wall_end <= e[9:0];
			end
			default: ;
		endcase
		if (state_q == ST_DY || (state_q == ST_IDLE)) begin
			sdx_q <= (state_q == ST_IDLE) ? 24'd0 : ddx_q >> 1;
		end
		if (state_q == ST_DYW && ddone) sdy_q <= sat24(dquot) >> 1;
		if (state_q == ST_DY && ray_q.ry == '0) sdy_q <= grc_pkg::DIST_MAX >> 1;
	end
endmodule
`default_nettype wire
